@@ rtl/tlma_pkg.sv @@
// Shared constants for the task load moving average unit.
package tlma_pkg;

  localparam int MAX_WINDOW = 1024;
  localparam int PTR_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
  localparam int SAMPLE_W   = 32;
  localparam int PERIOD_W   = 20;
  localparam int LOAD_W     = 24;
  localparam int FRAC_W     = 16;
  localparam int SUM_W      = SAMPLE_W + PTR_W;
  localparam int DIVQ_W     = SAMPLE_W + FRAC_W;
  localparam int STEP_W     = $clog2(DIVQ_W);

  localparam logic [PERIOD_W-1:0] US_PER_SECOND = PERIOD_W'(1000000);
  localparam logic [PERIOD_W-1:0] RESET_PERIOD  = PERIOD_W'(1000);
  localparam logic [LOAD_W-1:0]   LOAD_MAX      = {LOAD_W{1'b1}};

  localparam int RESET_LEN_RAW = 1000000 / 1000;
  localparam int RESET_LEN     = (RESET_LEN_RAW > MAX_WINDOW) ? MAX_WINDOW :
                                 ((RESET_LEN_RAW < 1) ? 1 : RESET_LEN_RAW);

endpackage

@@ rtl/task_load_moving_average_unit.sv @@
// Sliding-window moving average of task run times with load in Q8.16.
//
// Each request carries one run time in microseconds. The sample goes into a
// 1024-entry ring memory and into a running sum; once the window is full the
// oldest sample, read from the ring in the cycle the request is taken, leaves
// the sum. The result gives the mean over the held samples and the load (mean
// divided by the period) as unsigned Q8.16, saturated at the top and zero for
// a zero period. Before the next accept a request passes the idle state that
// takes it and reads the oldest sample, the update of the sum and ring, the
// steps for the mean and then for the load on one shared restoring divider
// that retires one quotient bit per cycle, and the handoff of the result to
// the output register. The output register holds a finished result while the
// next request is already at work; a second result waits in the handoff
// state until the first is taken. A period write clears the window and then
// runs the divider to work out the window length, max(1, 1000000 / period)
// capped at 1024 (1024 for a zero period), before the next request is taken.
// The ring gets no clearing pass: read data is only used after a write.
module task_load_moving_average_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tlma_pkg::PERIOD_W-1:0]  cfg_period_us,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [tlma_pkg::SAMPLE_W-1:0]  in_run_time_us,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tlma_pkg::SAMPLE_W-1:0]  out_average_us,
  output logic [tlma_pkg::LOAD_W-1:0]    out_load_q16
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEN,
    S_SUM,
    S_AVG,
    S_LOAD,
    S_OUT
  } state_t;

  // control state
  state_t                        state_r, state_nxt;
  logic [tlma_pkg::PERIOD_W-1:0] period_r, period_nxt;
  logic [tlma_pkg::CNT_W-1:0]    len_r, len_nxt;
  logic [tlma_pkg::PTR_W-1:0]    wp_r, wp_nxt;
  logic [tlma_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [tlma_pkg::SUM_W-1:0]    sum_r, sum_nxt;
  logic                          full_r, full_nxt;
  logic [tlma_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic                          out_valid_r, out_valid_nxt;

  // payload
  logic [tlma_pkg::SAMPLE_W-1:0] sample_r, sample_nxt;
  logic [tlma_pkg::DIVQ_W-1:0]   q_r, q_nxt;
  logic [tlma_pkg::PERIOD_W-1:0] rem_r, rem_nxt;
  logic [tlma_pkg::PERIOD_W-1:0] dvs_r, dvs_nxt;
  logic [tlma_pkg::SAMPLE_W-1:0] avg_r, avg_nxt;
  logic [tlma_pkg::LOAD_W-1:0]   load_r, load_nxt;
  logic [tlma_pkg::SAMPLE_W-1:0] out_avg_r, out_avg_nxt;
  logic [tlma_pkg::LOAD_W-1:0]   out_load_r, out_load_nxt;

  // ring memory
  logic [tlma_pkg::SAMPLE_W-1:0] ring [tlma_pkg::MAX_WINDOW];
  logic [tlma_pkg::SAMPLE_W-1:0] rd_data_r;
  logic                          rd_en;
  logic                          wr_en;
  logic [tlma_pkg::PTR_W-1:0]    rd_addr;
  logic [tlma_pkg::CNT_W-1:0]    wp_ext;
  logic [tlma_pkg::CNT_W-1:0]    oldest;

  // divider step
  logic [tlma_pkg::PERIOD_W:0]   rem_sh;
  logic                          div_ge;
  logic [tlma_pkg::PERIOD_W-1:0] rem_step;
  logic [tlma_pkg::DIVQ_W-1:0]   q_step;
  logic                          step_last;

  // update stage
  logic [tlma_pkg::SUM_W-1:0]    sum_new;
  logic [tlma_pkg::SUM_W-1:0]    drop_val;
  logic [tlma_pkg::CNT_W-1:0]    count_new;
  logic [tlma_pkg::PERIOD_W-1:0] q_len;

  assign cfg_ready      = (state_r == S_IDLE);
  assign in_ready       = (state_r == S_IDLE) && !cfg_valid;
  assign out_valid      = out_valid_r;
  assign out_average_us = out_avg_r;
  assign out_load_q16   = out_load_r;

  // Oldest entry sits count samples behind the write pointer, modulo the ring.
  assign wp_ext = tlma_pkg::CNT_W'(wp_r);
  always_comb begin
    if (wp_ext >= count_r) begin
      oldest = wp_ext - count_r;
    end else begin
      oldest = wp_ext + tlma_pkg::CNT_W'(tlma_pkg::MAX_WINDOW) - count_r;
    end
  end
  assign rd_addr = oldest[tlma_pkg::PTR_W-1:0];

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  assign rem_sh    = {rem_r, q_r[tlma_pkg::DIVQ_W-1]};
  assign div_ge    = (rem_sh >= {1'b0, dvs_r});
  assign rem_step  = div_ge ? tlma_pkg::PERIOD_W'(rem_sh - {1'b0, dvs_r})
                            : rem_sh[tlma_pkg::PERIOD_W-1:0];
  assign q_step    = {q_r[tlma_pkg::DIVQ_W-2:0], div_ge};
  assign step_last = (step_r == '0);
  assign q_len     = q_step[tlma_pkg::PERIOD_W-1:0];

  // Drop the oldest sample only when the window was full at accept time.
  assign drop_val  = full_r ? tlma_pkg::SUM_W'(rd_data_r) : '0;
  assign sum_new   = sum_r - drop_val + tlma_pkg::SUM_W'(sample_r);
  assign count_new = full_r ? count_r : count_r + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    period_nxt    = period_r;
    len_nxt       = len_r;
    wp_nxt        = wp_r;
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    full_nxt      = full_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    sample_nxt    = sample_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    dvs_nxt       = dvs_r;
    avg_nxt       = avg_r;
    load_nxt      = load_r;
    out_avg_nxt   = out_avg_r;
    out_load_nxt  = out_load_r;
    rd_en         = 1'b0;
    wr_en         = 1'b0;

    // Release the output register once the result is taken.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (cfg_valid) begin
          // New period: clear the window and start the length division.
          period_nxt = cfg_period_us;
          wp_nxt     = '0;
          count_nxt  = '0;
          sum_nxt    = '0;
          q_nxt      = tlma_pkg::DIVQ_W'(tlma_pkg::US_PER_SECOND)
                       << (tlma_pkg::DIVQ_W - tlma_pkg::PERIOD_W);
          rem_nxt    = '0;
          dvs_nxt    = cfg_period_us;
          step_nxt   = tlma_pkg::STEP_W'(tlma_pkg::PERIOD_W - 1);
          state_nxt  = S_LEN;
        end else if (in_valid) begin
          // Take the request and read the oldest sample in the same edge.
          sample_nxt = in_run_time_us;
          full_nxt   = (count_r >= len_r);
          rd_en      = 1'b1;
          state_nxt  = S_SUM;
        end
      end
      S_LEN: begin
        q_nxt    = q_step;
        rem_nxt  = rem_step;
        step_nxt = step_r - 1'b1;
        if (step_last) begin
          // Clamp the length to one at least and the ring depth at most.
          if ((period_r == '0) ||
              (q_len > tlma_pkg::PERIOD_W'(tlma_pkg::MAX_WINDOW))) begin
            len_nxt = tlma_pkg::CNT_W'(tlma_pkg::MAX_WINDOW);
          end else if (q_len == '0) begin
            len_nxt = tlma_pkg::CNT_W'(1);
          end else begin
            len_nxt = q_len[tlma_pkg::CNT_W-1:0];
          end
          state_nxt = S_IDLE;
        end
      end
      S_SUM: begin
        // Write the new sample, advance the pointer, start the mean.
        wr_en     = 1'b1;
        sum_nxt   = sum_new;
        count_nxt = count_new;
        wp_nxt    = (wp_r == tlma_pkg::PTR_W'(tlma_pkg::MAX_WINDOW - 1)) ? '0
                                                                          : wp_r + 1'b1;
        q_nxt     = tlma_pkg::DIVQ_W'(sum_new) << (tlma_pkg::DIVQ_W - tlma_pkg::SUM_W);
        rem_nxt   = '0;
        dvs_nxt   = tlma_pkg::PERIOD_W'(count_new);
        step_nxt  = tlma_pkg::STEP_W'(tlma_pkg::SUM_W - 1);
        state_nxt = S_AVG;
      end
      S_AVG: begin
        q_nxt    = q_step;
        rem_nxt  = rem_step;
        step_nxt = step_r - 1'b1;
        if (step_last) begin
          // Mean is done; divide mean * 2^16 by the period next.
          avg_nxt   = q_step[tlma_pkg::SAMPLE_W-1:0];
          q_nxt     = {q_step[tlma_pkg::SAMPLE_W-1:0], tlma_pkg::FRAC_W'(0)};
          rem_nxt   = '0;
          dvs_nxt   = period_r;
          step_nxt  = tlma_pkg::STEP_W'(tlma_pkg::DIVQ_W - 1);
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        q_nxt    = q_step;
        rem_nxt  = rem_step;
        step_nxt = step_r - 1'b1;
        if (step_last) begin
          if (period_r == '0) begin
            load_nxt = '0;
          end else if (q_step[tlma_pkg::DIVQ_W-1:tlma_pkg::LOAD_W] != '0) begin
            load_nxt = tlma_pkg::LOAD_MAX;
          end else begin
            load_nxt = q_step[tlma_pkg::LOAD_W-1:0];
          end
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // Hold until the output register is free.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_avg_nxt   = avg_r;
          out_load_nxt  = load_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      period_r    <= tlma_pkg::RESET_PERIOD;
      len_r       <= tlma_pkg::CNT_W'(tlma_pkg::RESET_LEN);
      wp_r        <= '0;
      count_r     <= '0;
      sum_r       <= '0;
      full_r      <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      period_r    <= period_nxt;
      len_r       <= len_nxt;
      wp_r        <= wp_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      full_r      <= full_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sample_r   <= sample_nxt;
    q_r        <= q_nxt;
    rem_r      <= rem_nxt;
    dvs_r      <= dvs_nxt;
    avg_r      <= avg_nxt;
    load_r     <= load_nxt;
    out_avg_r  <= out_avg_nxt;
    out_load_r <= out_load_nxt;
  end

  // Read happens at accept, write in the next cycle, so a full ring that reads
  // and overwrites the same entry still sees the old sample.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring[wp_r] <= sample_r;
    end
    if (rd_en) begin
      rd_data_r <= ring[rd_addr];
    end
  end

  a_count_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= len_r)
    else $error("sample count exceeds window length");

  a_avg_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_AVG) |-> (count_r != '0))
    else $error("mean division with empty window");

  a_accept_to_update: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_SUM))
    else $error("accepted request did not reach the update stage");

  a_result_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_OUT) && (!out_valid_r || out_ready)) |=>
      (out_valid_r && (state_r == S_IDLE)))
    else $error("finished result not handed to the output register");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    (len_r != '0) && (len_r <= tlma_pkg::CNT_W'(tlma_pkg::MAX_WINDOW)))
    else $error("window length out of range");

endmodule
